FILE: hw/rtl/rfft_pkg.sv
package rfft_pkg;

  // Twiddle circle is 4096 steps; only the first half of it is ever used.
  localparam int TW_DEPTH = 2048;
  localparam int TW_IDX_W = 11;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2 = 1'd1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic [9:0]        bin_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cpoint_t;

  typedef struct packed {
    logic                inv;
    logic [TW_IDX_W-1:0] tw_idx;
  } bf_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_BR_RD,
    ST_BR_WAIT,
    ST_BR_WR1,
    ST_BR_WR2,
    ST_BF_RD,
    ST_BF_P1,
    ST_BF_P2,
    ST_BF_P3,
    ST_BF_P4,
    ST_BF_WA,
    ST_BF_WB
  } state_t;

  typedef logic [31:0] tw_rom_t [TW_DEPTH];

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  // sin of pi*u/2048 in Q2.30, u up to 512
  function automatic logic [63:0] sin_q30(input logic [9:0] u);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = ({54'd0, u} * PI_Q30) >> 11;
    x2 = qmul(x, x);
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - qmul(x2, t) / 64'd42;
    t  = Q30_ONE - qmul(x2, t) / 64'd20;
    t  = Q30_ONE - qmul(x2, t) / 64'd6;
    return qmul(x, t);
  endfunction

  function automatic logic [63:0] cos_q30(input logic [9:0] u);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = ({54'd0, u} * PI_Q30) >> 11;
    x2 = qmul(x, x);
    t  = Q30_ONE - x2 / 64'd56;
    t  = Q30_ONE - qmul(x2, t) / 64'd30;
    t  = Q30_ONE - qmul(x2, t) / 64'd12;
    return Q30_ONE - qmul(x2, t) / 64'd2;
  endfunction

  function automatic logic [15:0] to_q15(input logic [63:0] v);
    logic [63:0] r;
    r = (v + 64'd16384) >> 15;
    return (r > 64'd32767) ? 16'd32767 : r[15:0];
  endfunction

  // {cos, sin} of 2*pi*t/4096, Q1.15 each
  function automatic logic [31:0] tw_entry(input logic [11:0] t);
    logic [1:0]  q;
    logic [9:0]  r;
    logic [15:0] cc;
    logic [15:0] ss;
    logic [15:0] c;
    logic [15:0] s;
    q = t[11:10];
    r = t[9:0];
    if (r <= 10'd512) begin
      cc = to_q15(cos_q30(r));
      ss = to_q15(sin_q30(r));
    end else begin
      cc = to_q15(sin_q30(10'd0 - r));
      ss = to_q15(cos_q30(10'd0 - r));
    end
    case (q)
      2'd0: begin c = cc;          s = ss;          end
      2'd1: begin c = 16'd0 - ss;  s = cc;          end
      2'd2: begin c = 16'd0 - cc;  s = 16'd0 - ss;  end
      default: begin c = ss;       s = 16'd0 - cc;  end
    endcase
    return {c, s};
  endfunction

  function automatic tw_rom_t tw_build();
    tw_rom_t rom;
    for (int i = 0; i < TW_DEPTH; i++) begin
      rom[i] = tw_entry(12'(i));
    end
    return rom;
  endfunction

endpackage

FILE: hw/rtl/rfft_bfly.sv
// Four-stage butterfly: twiddle fetch, products, rounding, add/sub + saturate.
module rfft_bfly (
  input  logic              clk,
  input  rfft_pkg::bf_ctl_t ctl,
  input  rfft_pkg::cpoint_t a_in,
  input  rfft_pkg::cpoint_t b_in,
  output rfft_pkg::cpoint_t a_out,
  output rfft_pkg::cpoint_t b_out
);

  localparam rfft_pkg::tw_rom_t TW_ROM = rfft_pkg::tw_build();

  logic signed [15:0] c_r;
  logic signed [15:0] s_r;
  logic               inv1_r, inv2_r, inv3_r;
  rfft_pkg::cpoint_t  a1_r, b1_r, a2_r, a3_r;

  logic signed [16:0] c_ext;
  logic signed [16:0] s_eff;
  logic signed [48:0] prr_r, pii_r, pir_r, pri_r;

  logic signed [49:0] sum_re, sum_im;
  logic signed [34:0] pr_r, pim_r;

  logic signed [35:0] ar, ai, prx, pix;

  function automatic logic signed [31:0] bf_out(input logic signed [35:0] v,
                                                input logic inv);
    logic signed [35:0] r;
    r = inv ? ((v + 36'sd1) >>> 1) : v;
    if (r > 36'sd2147483647) return 32'sh7fffffff;
    if (r < -36'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  // stage 1: twiddle ROM
  always_ff @(posedge clk) begin
    {c_r, s_r} <= TW_ROM[ctl.tw_idx];
    inv1_r     <= ctl.inv;
    a1_r       <= a_in;
    b1_r       <= b_in;
  end

  // stage 2: products; inverse flips the sine
  assign c_ext = {c_r[15], c_r};
  assign s_eff = inv1_r ? -$signed({s_r[15], s_r}) : $signed({s_r[15], s_r});

  always_ff @(posedge clk) begin
    prr_r  <= b1_r.re * c_ext;
    pii_r  <= b1_r.im * s_eff;
    pir_r  <= b1_r.im * c_ext;
    pri_r  <= b1_r.re * s_eff;
    inv2_r <= inv1_r;
    a2_r   <= a1_r;
  end

  // stage 3: round off the Q15 twiddle fraction (floor of biased sum)
  assign sum_re = $signed({prr_r[48], prr_r}) - $signed({pii_r[48], pii_r}) + 50'sd16384;
  assign sum_im = $signed({pir_r[48], pir_r}) + $signed({pri_r[48], pri_r}) + 50'sd16384;

  always_ff @(posedge clk) begin
    pr_r   <= sum_re[49:15];
    pim_r  <= sum_im[49:15];
    inv3_r <= inv2_r;
    a3_r   <= a2_r;
  end

  // stage 4: add/sub, optional halving, saturate
  assign ar  = 36'(a3_r.re);
  assign ai  = 36'(a3_r.im);
  assign prx = 36'(pr_r);
  assign pix = 36'(pim_r);

  always_ff @(posedge clk) begin
    a_out.re <= bf_out(ar + prx, inv3_r);
    a_out.im <= bf_out(ai + pix, inv3_r);
    b_out.re <= bf_out(ar - prx, inv3_r);
    b_out.im <= bf_out(ai - pix, inv3_r);
  end

endmodule

FILE: hw/rtl/radix2_fft_engine.sv
// Radix-2 decimation-in-time complex FFT, in place over one point store.
//
// Input channel (in_valid / in_stall / in_data): a beat with mode LOAD
// writes the next sample; the beat that completes N = 2^size_log2 samples
// starts the transform. A beat with mode READ returns the bin at bin_index
// (wrapped to N) from the store on the result channel (out_valid /
// out_stall / out_data). Loads produce no result beat.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_wdata) is always
// ready: index 0 direction (0 forward, 1 inverse halving each stage),
// index 1 size_log2. Write it only while the block is idle.
//
// Timing: a read's result passes through the store's read register, then the
// output register. The final load starts the transform, during which in_stall
// is high: bit reversal visits each index in ST_BR_RD and swaps pairs through
// ST_BR_WAIT/WR1/WR2; then each of the N/2*log2(N) butterflies runs ST_BF_RD to
// ST_BF_WB via the single memory write port and the 4-stage butterfly pipeline.
// Reset: the store is zeroed by a sweep over its 2^floor(log2(MAX_POINTS))
// entries (at most 4096) with in_stall high; config is taken meanwhile.
// A stalled result holds in the output register; one more read may then be
// accepted and waits until the register frees up.
module radix2_fft_engine #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rfft_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rfft_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rfft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfft_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int LOG_MAX_RAW = $clog2(MAX_POINTS + 1) - 1;
  localparam int LOG_MAX     = (LOG_MAX_RAW > 12) ? 12 : LOG_MAX_RAW;
  localparam int IDX_W       = LOG_MAX;
  localparam int DEPTH       = 1 << LOG_MAX;
  localparam int CNT_W       = IDX_W + 1;
  localparam logic [3:0] LOG_MAX_L = 4'(LOG_MAX);

  rfft_pkg::state_t state_r, state_nxt;

  logic                 direction_r, direction_nxt;
  logic [3:0]           size_log2_r, size_log2_nxt;
  logic [CNT_W-1:0]     load_cnt_r, load_cnt_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;       // clear sweep / bit-rev index / butterfly
  logic [3:0]           stage_r, stage_nxt;
  logic                 inv_r, inv_nxt;
  logic [3:0]           len_log2_r, len_log2_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rfft_pkg::out_item_t  out_data_r, out_data_nxt;

  // point store
  rfft_pkg::cpoint_t mem [DEPTH];
  rfft_pkg::cpoint_t rd_a_r, rd_b_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa, mem_ra_a, mem_ra_b;
  rfft_pkg::cpoint_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a_r <= mem[mem_ra_a];
    rd_b_r <= mem[mem_ra_b];
  end

  // size in use for loads and reads
  logic [3:0]       act_l;
  logic [CNT_W-1:0] act_n, act_mask;
  logic [21:0]      bin_wide;
  logic [IDX_W-1:0] bin_idx;
  logic [CNT_W-1:0] ld_base, ld_next;
  rfft_pkg::cpoint_t ld_point;

  assign act_l    = (size_log2_r < 4'd1) ? 4'd1 :
                    ((size_log2_r > LOG_MAX_L) ? LOG_MAX_L : size_log2_r);
  assign act_n    = CNT_W'(1) << act_l;
  assign act_mask = act_n - CNT_W'(1);
  assign bin_wide = 22'(in_data.bin_index);
  assign bin_idx  = bin_wide[IDX_W-1:0] & act_mask[IDX_W-1:0];
  assign ld_base  = (load_cnt_r >= act_n) ? '0 : load_cnt_r;
  assign ld_next  = ld_base + CNT_W'(1);
  assign ld_point.re = 32'(in_data.sample_re);
  assign ld_point.im = 32'(in_data.sample_im);

  // transform addressing
  logic [CNT_W-1:0] t_mask;
  logic [IDX_W-1:0] br_i, br_rev, br_j;
  logic             br_last;
  logic [IDX_W-1:0] bf_m, bf_half, bf_k, bf_pa, bf_pb;
  logic [11:0]      k_ext, tw_full;
  logic             bf_last, stage_last;

  assign t_mask = (CNT_W'(1) << len_log2_r) - CNT_W'(1);
  assign br_i   = cnt_r[IDX_W-1:0];

  always_comb begin
    for (int b = 0; b < IDX_W; b++) begin
      br_rev[b] = br_i[IDX_W-1-b];
    end
  end

  assign br_j    = br_rev >> (LOG_MAX_L - len_log2_r);
  assign br_last = (cnt_r == t_mask);

  assign bf_m    = cnt_r[IDX_W-1:0];
  assign bf_half = IDX_W'(1) << (stage_r - 4'd1);
  assign bf_k    = bf_m & (bf_half - IDX_W'(1));
  assign bf_pa   = ((bf_m >> (stage_r - 4'd1)) << stage_r) | bf_k;
  assign bf_pb   = bf_pa | bf_half;
  assign k_ext   = 12'(bf_k);
  assign tw_full = k_ext << (4'd12 - stage_r);
  assign bf_last    = (cnt_r == (t_mask >> 1));
  assign stage_last = (stage_r == len_log2_r);

  rfft_pkg::bf_ctl_t bf_ctl;
  rfft_pkg::cpoint_t bf_a_out, bf_b_out;

  assign bf_ctl.inv    = inv_r;
  assign bf_ctl.tw_idx = tw_full[rfft_pkg::TW_IDX_W-1:0];

  rfft_bfly u_bfly (
    .clk   (clk),
    .ctl   (bf_ctl),
    .a_in  (rd_a_r),
    .b_in  (rd_b_r),
    .a_out (bf_a_out),
    .b_out (bf_b_out)
  );

  // next state
  always_comb begin
    state_nxt     = state_r;
    direction_nxt = direction_r;
    size_log2_nxt = size_log2_r;
    load_cnt_nxt  = load_cnt_r;
    cnt_nxt       = cnt_r;
    stage_nxt     = stage_r;
    inv_nxt       = inv_r;
    len_log2_nxt  = len_log2_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_valid) begin
      case (cfg_index)
        rfft_pkg::REG_DIRECTION: direction_nxt = cfg_wdata[0];
        rfft_pkg::REG_SIZE_LOG2: size_log2_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rfft_pkg::ST_CLEAR: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = rfft_pkg::ST_IDLE;
        end
      end
      rfft_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.mode == rfft_pkg::MODE_READ) begin
            rd_idx_nxt = bin_idx;
            state_nxt  = rfft_pkg::ST_RD_WAIT;
          end else if (ld_next == act_n) begin
            load_cnt_nxt = '0;
            len_log2_nxt = act_l;
            inv_nxt      = direction_r;
            cnt_nxt      = '0;
            state_nxt    = rfft_pkg::ST_BR_RD;
          end else begin
            load_cnt_nxt = ld_next;
          end
        end
      end
      rfft_pkg::ST_RD_WAIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.out_re = rd_a_r.re;
          out_data_nxt.out_im = rd_a_r.im;
          state_nxt           = rfft_pkg::ST_IDLE;
        end
      end
      rfft_pkg::ST_BR_RD, rfft_pkg::ST_BR_WR2: begin
        if (state_r == rfft_pkg::ST_BR_RD && br_i < br_j) begin
          state_nxt = rfft_pkg::ST_BR_WAIT;
        end else if (br_last) begin
          cnt_nxt   = '0;
          stage_nxt = 4'd1;
          state_nxt = rfft_pkg::ST_BF_RD;
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = rfft_pkg::ST_BR_RD;
        end
      end
      rfft_pkg::ST_BR_WAIT: state_nxt = rfft_pkg::ST_BR_WR1;
      rfft_pkg::ST_BR_WR1:  state_nxt = rfft_pkg::ST_BR_WR2;
      rfft_pkg::ST_BF_RD:   state_nxt = rfft_pkg::ST_BF_P1;
      rfft_pkg::ST_BF_P1:   state_nxt = rfft_pkg::ST_BF_P2;
      rfft_pkg::ST_BF_P2:   state_nxt = rfft_pkg::ST_BF_P3;
      rfft_pkg::ST_BF_P3:   state_nxt = rfft_pkg::ST_BF_P4;
      rfft_pkg::ST_BF_P4:   state_nxt = rfft_pkg::ST_BF_WA;
      rfft_pkg::ST_BF_WA:   state_nxt = rfft_pkg::ST_BF_WB;
      rfft_pkg::ST_BF_WB: begin
        if (!bf_last) begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = rfft_pkg::ST_BF_RD;
        end else if (!stage_last) begin
          cnt_nxt   = '0;
          stage_nxt = stage_r + 4'd1;
          state_nxt = rfft_pkg::ST_BF_RD;
        end else begin
          state_nxt = rfft_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rfft_pkg::ST_IDLE;
    endcase
  end

  // outputs: memory ports and input stall
  always_comb begin
    in_stall = 1'b1;
    mem_we   = 1'b0;
    mem_wa   = br_i;
    mem_wd   = '0;
    mem_ra_a = br_i;
    mem_ra_b = br_j;

    case (state_r)
      rfft_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r[IDX_W-1:0];
      end
      rfft_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        mem_ra_a = bin_idx;
        if (in_valid && in_data.mode == rfft_pkg::MODE_LOAD) begin
          mem_we = 1'b1;
          mem_wa = ld_base[IDX_W-1:0];
          mem_wd = ld_point;
        end
      end
      rfft_pkg::ST_RD_WAIT: mem_ra_a = rd_idx_r;
      rfft_pkg::ST_BR_RD, rfft_pkg::ST_BR_WAIT: ;
      rfft_pkg::ST_BR_WR1: begin
        mem_we = 1'b1;
        mem_wa = br_i;
        mem_wd = rd_b_r;
      end
      rfft_pkg::ST_BR_WR2: begin
        mem_we = 1'b1;
        mem_wa = br_j;
        mem_wd = rd_a_r;
      end
      rfft_pkg::ST_BF_RD, rfft_pkg::ST_BF_P1, rfft_pkg::ST_BF_P2,
      rfft_pkg::ST_BF_P3, rfft_pkg::ST_BF_P4: begin
        mem_ra_a = bf_pa;
        mem_ra_b = bf_pb;
      end
      rfft_pkg::ST_BF_WA: begin
        mem_ra_a = bf_pa;
        mem_ra_b = bf_pb;
        mem_we   = 1'b1;
        mem_wa   = bf_pa;
        mem_wd   = bf_a_out;
      end
      rfft_pkg::ST_BF_WB: begin
        mem_ra_a = bf_pa;
        mem_ra_b = bf_pb;
        mem_we   = 1'b1;
        mem_wa   = bf_pb;
        mem_wd   = bf_b_out;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfft_pkg::ST_CLEAR;
      direction_r <= 1'b0;
      size_log2_r <= 4'd10;
      load_cnt_r  <= '0;
      cnt_r       <= '0;
      stage_r     <= 4'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      direction_r <= direction_nxt;
      size_log2_r <= size_log2_nxt;
      load_cnt_r  <= load_cnt_nxt;
      cnt_r       <= cnt_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inv_r      <= inv_nxt;
    len_log2_r <= len_log2_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

FILE: hw/rtl/rfft_chk.sv
module rfft_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input rfft_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input rfft_pkg::out_item_t             out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // reset empties the output and starts the clearing sweep
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled during store clear");

  // a read into an empty output shows up once ST_RD_WAIT has loaded the output register
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode == rfft_pkg::MODE_READ && !out_valid
      |-> ##2 out_valid)
    else $error("read result missing");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode == rfft_pkg::MODE_READ |=> in_stall)
    else $error("input taken while read pending");

endmodule

bind radix2_fft_engine rfft_chk u_rfft_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
